>>> rtl/quaternion_alu_unit_macros.svh
// assertion macros for the quaternion alu checker
// no dependencies
`ifndef QUATERNION_ALU_UNIT_MACROS_SVH
`define QUATERNION_ALU_UNIT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define QALU_ASSERT_CLK(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("qalu check failed");

// clocked check that also holds during reset
`define QALU_ASSERT_ALL(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) \
		else $error("qalu reset check failed");

`endif

>>> rtl/qalu_pkg.sv
// shared types, opcodes and widths for the quaternion alu
// no dependencies
`default_nettype none

package qalu_pkg;

	localparam int DATA_W        = 32;
	localparam int CMD_W         = 4;
	localparam int RES_W         = 2 * DATA_W + 4;
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int BIG_EXP       = 62;

	localparam logic [CMD_W-1:0] OP_ADD   = 4'd0;
	localparam logic [CMD_W-1:0] OP_SUB   = 4'd1;
	localparam logic [CMD_W-1:0] OP_NEG   = 4'd2;
	localparam logic [CMD_W-1:0] OP_CONJ  = 4'd3;
	localparam logic [CMD_W-1:0] OP_HAM   = 4'd4;
	localparam logic [CMD_W-1:0] OP_CMUL  = 4'd5;
	localparam logic [CMD_W-1:0] OP_SCALE = 4'd6;
	localparam logic [CMD_W-1:0] OP_DIV   = 4'd7;
	localparam logic [CMD_W-1:0] OP_INV   = 4'd8;

	typedef logic signed [DATA_W-1:0] comp_t;
	typedef logic signed [RES_W-1:0]  wide_t;

	typedef struct packed {
		logic             valid;
		logic [CMD_W-1:0] cmd;
	} ctl_t;

	typedef struct packed {
		logic       dz;
		logic [3:0] neg;
		logic [3:0] npos;
		logic [3:0] nneg;
	} dtag_t;

endpackage

`default_nettype wire

>>> rtl/qalu_cmd_if.sv
// command channel of the quaternion alu: opcode, two quaternions and a scalar
// depends on qalu_pkg
`default_nettype none

interface qalu_cmd_if import qalu_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	comp_t            a_re;
	comp_t            a_i;
	comp_t            a_j;
	comp_t            a_k;
	comp_t            b_re;
	comp_t            b_i;
	comp_t            b_j;
	comp_t            b_k;
	comp_t            factor;

	modport source (output valid, command, a_re, a_i, a_j, a_k, b_re, b_i, b_j, b_k, factor,
		input ready);
	modport sink (input valid, command, a_re, a_i, a_j, a_k, b_re, b_i, b_j, b_k, factor,
		output ready);
endinterface

`default_nettype wire

>>> rtl/qalu_res_if.sv
// result channel of the quaternion alu: one quaternion and two flags
// depends on qalu_pkg
`default_nettype none

interface qalu_res_if import qalu_pkg::*; ();
	logic  valid;
	logic  ready;
	comp_t r_re;
	comp_t r_i;
	comp_t r_j;
	comp_t r_k;
	logic  saturated;
	logic  divide_error;

	modport source (output valid, r_re, r_i, r_j, r_k, saturated, divide_error, input ready);
	modport sink (input valid, r_re, r_i, r_j, r_k, saturated, divide_error, output ready);
endinterface

`default_nettype wire

>>> rtl/qalu_mul_stage.sv
// first stage: operand selection and sixteen truncated fixed point products
// depends on qalu_pkg
`default_nettype none

module qalu_mul_stage import qalu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  ctl_t  ctl_in,
	input  comp_t a [4],
	input  comp_t b [4],
	input  comp_t f,
	output ctl_t  ctl_s1,
	output comp_t a_s1 [4],
	output comp_t b_s1 [4],
	output comp_t f_s1,
	output logic signed [2*DATA_W-FRAC_BITS-1:0] p_s1 [4][4]
);

	logic signed [2*DATA_W-1:0] full [4][4];
	comp_t                      yop  [4][4];

	always_comb begin
		for (int x = 0; x < 4; x++) begin
			for (int y = 0; y < 4; y++) begin
				if (x != y) begin
					yop[x][y] = b[y];
				end else if (ctl_in.cmd == OP_SCALE) begin
					yop[x][y] = f;
				end else if (ctl_in.cmd == OP_INV) begin
					yop[x][y] = a[x];
				end else begin
					yop[x][y] = b[y];
				end
				full[x][y] = a[x] * yop[x][y];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	// floor of the product over two to the fraction bits
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= a;
			b_s1 <= b;
			f_s1 <= f;
			for (int x = 0; x < 4; x++) begin
				for (int y = 0; y < 4; y++) begin
					p_s1[x][y] <= full[x][y][2*DATA_W-1:FRAC_BITS];
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/qalu_sum_stage.sv
// second stage: product sums, add, subtract, negate and conjugate, and divider set-up
// depends on qalu_pkg
`default_nettype none

module qalu_sum_stage import qalu_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int NUM_W     = DATA_W + FRAC_BITS,
	parameter int DEN_W     = 2 * DATA_W + 1 - FRAC_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  ctl_t  ctl_s1,
	input  comp_t a_s1 [4],
	input  comp_t b_s1 [4],
	input  comp_t f_s1,
	input  logic signed [2*DATA_W-FRAC_BITS-1:0] p_s1 [4][4],
	output ctl_t  ctl_s2,
	output dtag_t tag_s2,
	output wide_t r_s2 [4],
	output logic [NUM_W-1:0] num_s2 [4],
	output logic [DEN_W-1:0] den_s2
);

	wide_t              pw  [4][4];
	wide_t              aw  [4];
	wide_t              bw  [4];
	wide_t              ham [4];
	wide_t              r   [4];
	logic [DATA_W-1:0]  amag [4];
	logic [DATA_W-1:0]  fmag;
	logic [DEN_W-1:0]   nsum;
	logic [DEN_W-1:0]   den;
	logic               dneg;
	dtag_t              tag;

	always_comb begin
		for (int x = 0; x < 4; x++) begin
			for (int y = 0; y < 4; y++) begin
				pw[x][y] = wide_t'(p_s1[x][y]);
			end
			aw[x]   = wide_t'(a_s1[x]);
			bw[x]   = wide_t'(b_s1[x]);
			amag[x] = a_s1[x][DATA_W-1] ? (~a_s1[x] + 1'b1) : a_s1[x];
		end
		fmag = f_s1[DATA_W-1] ? (~f_s1 + 1'b1) : f_s1;

		ham[0] = pw[0][0] - pw[1][1] - pw[2][2] - pw[3][3];
		ham[1] = pw[0][1] + pw[1][0] + pw[2][3] - pw[3][2];
		ham[2] = pw[0][2] - pw[1][3] + pw[2][0] + pw[3][1];
		ham[3] = pw[0][3] + pw[1][2] - pw[2][1] + pw[3][0];

		// squared norm, each truncated square is non-negative
		nsum = DEN_W'(p_s1[0][0]) + DEN_W'(p_s1[1][1]) + DEN_W'(p_s1[2][2])
			+ DEN_W'(p_s1[3][3]);

		for (int t = 0; t < 4; t++) begin
			unique case (ctl_s1.cmd)
				OP_ADD:   r[t] = aw[t] + bw[t];
				OP_SUB:   r[t] = aw[t] - bw[t];
				OP_NEG:   r[t] = -aw[t];
				OP_CONJ:  r[t] = (t == 0) ? aw[t] : -aw[t];
				OP_HAM:   r[t] = ham[t];
				OP_CMUL:  r[t] = pw[t][t];
				OP_SCALE: r[t] = pw[t][t];
				default:  r[t] = '0;
			endcase
		end

		if (ctl_s1.cmd == OP_INV) begin
			den  = nsum;
			dneg = 1'b0;
		end else begin
			den  = DEN_W'(fmag);
			dneg = f_s1[DATA_W-1];
		end

		tag.dz = (den == '0);
		for (int t = 0; t < 4; t++) begin
			// inverse divides the conjugate, so the vector part changes sign
			if (ctl_s1.cmd == OP_INV && t != 0) begin
				tag.nneg[t] = !a_s1[t][DATA_W-1] && (a_s1[t] != '0);
				tag.npos[t] = a_s1[t][DATA_W-1];
			end else begin
				tag.nneg[t] = a_s1[t][DATA_W-1];
				tag.npos[t] = !a_s1[t][DATA_W-1] && (a_s1[t] != '0);
			end
			tag.neg[t] = tag.nneg[t] ^ dneg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag;
			den_s2 <= den;
			r_s2   <= r;
			for (int t = 0; t < 4; t++) begin
				num_s2[t] <= {amag[t], {FRAC_BITS{1'b0}}};
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/qalu_div_pipe.sv
// restoring divider, one quotient bit per stage, four lanes sharing one divisor
// depends on qalu_pkg
`default_nettype none

module qalu_div_pipe import qalu_pkg::*; #(
	parameter int NUM_W = DATA_W + FRAC_BITS_DEF,
	parameter int DEN_W = 2 * DATA_W + 1 - FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ctl_t             ctl_in,
	input  dtag_t            tag_in,
	input  wide_t            r_in [4],
	input  logic [NUM_W-1:0] num_in [4],
	input  logic [DEN_W-1:0] den_in,
	output ctl_t             ctl_out,
	output dtag_t            tag_out,
	output wide_t            r_out [4],
	output logic [NUM_W-1:0] q_out [4]
);

	ctl_t             ctl_s [NUM_W];
	dtag_t            tag_s [NUM_W];
	wide_t            r_s   [NUM_W][4];
	logic [NUM_W-1:0] x_s   [NUM_W][4];
	logic [DEN_W-1:0] rem_s [NUM_W-1][4];
	logic [DEN_W-1:0] den_s [NUM_W-1];

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		ctl_t             ctl_p;
		dtag_t            tag_p;
		wide_t            r_p   [4];
		logic [NUM_W-1:0] x_p   [4];
		logic [DEN_W-1:0] rem_p [4];
		logic [DEN_W-1:0] den_p;
		logic [DEN_W:0]   trial [4];
		logic [DEN_W-1:0] rem_n [4];
		logic [NUM_W-1:0] x_n   [4];

		if (g == 0) begin : g_head
			assign ctl_p = ctl_in;
			assign tag_p = tag_in;
			assign r_p   = r_in;
			assign x_p   = num_in;
			assign den_p = den_in;
			for (genvar l = 0; l < 4; l++) begin : g_lane
				assign rem_p[l] = '0;
			end
		end else begin : g_body
			assign ctl_p = ctl_s[g-1];
			assign tag_p = tag_s[g-1];
			assign r_p   = r_s[g-1];
			assign x_p   = x_s[g-1];
			assign rem_p = rem_s[g-1];
			assign den_p = den_s[g-1];
		end

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				trial[l] = {rem_p[l], x_p[l][NUM_W-1]};
				if (trial[l] >= {1'b0, den_p}) begin
					rem_n[l] = DEN_W'(trial[l] - {1'b0, den_p});
					x_n[l]   = {x_p[l][NUM_W-2:0], 1'b1};
				end else begin
					rem_n[l] = trial[l][DEN_W-1:0];
					x_n[l]   = {x_p[l][NUM_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[g] <= '0;
			end else if (adv) begin
				ctl_s[g] <= ctl_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				tag_s[g] <= tag_p;
				r_s[g]   <= r_p;
				x_s[g]   <= x_n;
			end
		end

		if (g < NUM_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[g] <= rem_n;
					den_s[g] <= den_p;
				end
			end
		end
	end

	assign ctl_out = ctl_s[NUM_W-1];
	assign tag_out = tag_s[NUM_W-1];
	assign r_out   = r_s[NUM_W-1];
	assign q_out   = x_s[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/qalu_clip_stage.sv
// last stage: quotient sign, divide by zero handling, saturation and output register
// depends on qalu_pkg
`default_nettype none

module qalu_clip_stage import qalu_pkg::*; #(
	parameter int SAT_BITS = DATA_W,
	parameter int NUM_W    = DATA_W + FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  ctl_t             ctl_in,
	input  dtag_t            tag_in,
	input  wide_t            r_in [4],
	input  logic [NUM_W-1:0] q_in [4],
	output logic             valid_q,
	output comp_t            r_q [4],
	output logic             sat_q,
	output logic             err_q
);

	localparam wide_t HI  = (wide_t'(1) <<< (SAT_BITS - 1)) - wide_t'(1);
	localparam wide_t LO  = -HI - wide_t'(1);
	localparam wide_t BIG = wide_t'(1) <<< BIG_EXP;

	logic  is_div;
	wide_t v [4];
	wide_t qw;
	comp_t c [4];
	logic  sat;

	always_comb begin
		is_div = (ctl_in.cmd == OP_DIV) || (ctl_in.cmd == OP_INV);
		sat    = 1'b0;
		qw     = '0;
		for (int t = 0; t < 4; t++) begin
			qw = wide_t'({1'b0, q_in[t]});
			if (!is_div) begin
				v[t] = r_in[t];
			end else if (tag_in.dz) begin
				v[t] = tag_in.npos[t] ? BIG : (tag_in.nneg[t] ? -BIG : '0);
			end else begin
				v[t] = tag_in.neg[t] ? -qw : qw;
			end
			if (v[t] > HI) begin
				c[t] = HI[DATA_W-1:0];
				sat  = 1'b1;
			end else if (v[t] < LO) begin
				c[t] = LO[DATA_W-1:0];
				sat  = 1'b1;
			end else begin
				c[t] = v[t][DATA_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_q   <= c;
			sat_q <= sat;
			err_q <= is_div && tag_in.dz;
		end
	end

endmodule

`default_nettype wire

>>> rtl/quaternion_alu_unit.sv
// top level of the pipelined quaternion arithmetic unit
// depends on qalu_pkg, qalu_cmd_if, qalu_res_if and the four stage modules
//
//  channel  role    carries
//  cmd      sink    command, a_re..a_k, b_re..b_k, factor
//  res      source  r_re..r_k, saturated, divide_error
//
// one item per cycle unless a held result stalls the pipeline;
// the restoring divider resolves one quotient bit per stage
// every item passes all stages whatever its opcode, so results leave in order
// a held result stalls the whole pipeline; cmd.ready is low only while that happens
// reset clears the valid bits only, no clearing pass
`default_nettype none

module quaternion_alu_unit import qalu_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qalu_cmd_if.sink   cmd,
	qalu_res_if.source res
);

	localparam int SAT_BITS = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
	localparam int NUM_W    = DATA_W + FRAC_BITS;
	localparam int DEN_W    = 2 * DATA_W + 1 - FRAC_BITS;

	logic  adv;
	ctl_t  ctl_in;
	comp_t a [4];
	comp_t b [4];

	ctl_t  ctl_s1;
	comp_t a_s1 [4];
	comp_t b_s1 [4];
	comp_t f_s1;
	logic signed [2*DATA_W-FRAC_BITS-1:0] p_s1 [4][4];

	ctl_t             ctl_s2;
	dtag_t            tag_s2;
	wide_t            r_s2 [4];
	logic [NUM_W-1:0] num_s2 [4];
	logic [DEN_W-1:0] den_s2;

	ctl_t             ctl_d;
	dtag_t            tag_d;
	wide_t            r_d [4];
	logic [NUM_W-1:0] q_d [4];

	comp_t r_q [4];

	assign adv       = !res.valid || res.ready;
	assign cmd.ready = adv;
	assign ctl_in    = '{valid: cmd.valid, cmd: cmd.command};
	assign a         = '{cmd.a_re, cmd.a_i, cmd.a_j, cmd.a_k};
	assign b         = '{cmd.b_re, cmd.b_i, cmd.b_j, cmd.b_k};

	qalu_mul_stage #(
		.FRAC_BITS (FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl_in (ctl_in),
		.a      (a),
		.b      (b),
		.f      (cmd.factor),
		.ctl_s1 (ctl_s1),
		.a_s1   (a_s1),
		.b_s1   (b_s1),
		.f_s1   (f_s1),
		.p_s1   (p_s1)
	);

	qalu_sum_stage #(
		.FRAC_BITS (FRAC_BITS),
		.NUM_W     (NUM_W),
		.DEN_W     (DEN_W)
	) u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl_s1 (ctl_s1),
		.a_s1   (a_s1),
		.b_s1   (b_s1),
		.f_s1   (f_s1),
		.p_s1   (p_s1),
		.ctl_s2 (ctl_s2),
		.tag_s2 (tag_s2),
		.r_s2   (r_s2),
		.num_s2 (num_s2),
		.den_s2 (den_s2)
	);

	qalu_div_pipe #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_s2),
		.tag_in  (tag_s2),
		.r_in    (r_s2),
		.num_in  (num_s2),
		.den_in  (den_s2),
		.ctl_out (ctl_d),
		.tag_out (tag_d),
		.r_out   (r_d),
		.q_out   (q_d)
	);

	qalu_clip_stage #(
		.SAT_BITS (SAT_BITS),
		.NUM_W    (NUM_W)
	) u_clip (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_d),
		.tag_in  (tag_d),
		.r_in    (r_d),
		.q_in    (q_d),
		.valid_q (res.valid),
		.r_q     (r_q),
		.sat_q   (res.saturated),
		.err_q   (res.divide_error)
	);

	assign res.r_re = r_q[0];
	assign res.r_i  = r_q[1];
	assign res.r_j  = r_q[2];
	assign res.r_k  = r_q[3];

endmodule

`default_nettype wire

>>> rtl/qalu_check.sv
// port checker for the quaternion alu and its bind to the top level
// depends on qalu_pkg and quaternion_alu_unit_macros.svh
`default_nettype none

`include "quaternion_alu_unit_macros.svh"

module qalu_check import qalu_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  cmd_ready,
	input logic  res_valid,
	input logic  res_ready,
	input comp_t r_re,
	input comp_t r_i,
	input comp_t r_j,
	input comp_t r_k,
	input logic  saturated,
	input logic  divide_error
);

	`QALU_ASSERT_CLK(a_res_hold, clk, arst_n, res_valid && !res_ready |=> res_valid)
	`QALU_ASSERT_CLK(a_res_stable, clk, arst_n, res_valid && !res_ready |=> $stable(r_re) && $stable(r_i) && $stable(r_j) && $stable(r_k) && $stable(saturated) && $stable(divide_error))
	`QALU_ASSERT_CLK(a_stall_only, clk, arst_n, !cmd_ready |-> res_valid && !res_ready)
	`QALU_ASSERT_CLK(a_dz_sat, clk, arst_n, res_valid && divide_error |-> saturated == (r_re != '0 || r_i != '0 || r_j != '0 || r_k != '0))
	`QALU_ASSERT_ALL(a_reset_idle, clk, !arst_n |-> !res_valid)

endmodule

bind quaternion_alu_unit qalu_check u_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.cmd_ready    (cmd.ready),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.r_re         (res.r_re),
	.r_i          (res.r_i),
	.r_j          (res.r_j),
	.r_k          (res.r_k),
	.saturated    (res.saturated),
	.divide_error (res.divide_error)
);

`default_nettype wire

>>> sim/tb_top.sv
// testbench for quaternion_alu_unit: directed and random quaternion operations,
// every result checked field by field against an in-bench fixed point predictor
// depends on qalu_pkg, qalu_cmd_if, qalu_res_if and the rtl of quaternion_alu_unit
`default_nettype none

module tb_top import qalu_pkg::*; ();

	localparam int FRAC      = FRAC_BITS_DEF;
	localparam int LAT       = DATA_W + FRAC + 3;
	localparam int N_RANDOM  = 600;
	localparam longint SAT_HI = 64'sd2147483647;
	localparam longint SAT_LO = -64'sd2147483648;
	localparam longint BIG    = 64'sd1 <<< BIG_EXP;

	typedef struct {
		logic [CMD_W-1:0] op;
		comp_t            a [4];
		comp_t            b [4];
		comp_t            f;
	} quat_cmd_t;

	typedef struct {
		comp_t r [4];
		logic  sat;
		logic  err;
	} quat_res_t;

	class quat_scoreboard;
		quat_res_t expected_results [$];
		int        mismatches;
		int        checked;
		int        op_count [16];
		int        sat_seen;
		int        err_seen;

		function longint fx_mul(longint x, longint y);
			return (x * y) >>> FRAC;
		endfunction

		function longint fx_div(longint num, longint den, inout logic err);
			if (den == 0) begin
				err = 1'b1;
				if (num > 0) return BIG;
				if (num < 0) return -BIG;
				return 0;
			end
			return (num <<< FRAC) / den;
		endfunction

		function quat_res_t predict_quat(quat_cmd_t c);
			longint a [4];
			longint b [4];
			longint w [4];
			longint f;
			longint nrm;
			quat_res_t p;
			p.sat = 1'b0;
			p.err = 1'b0;
			for (int t = 0; t < 4; t++) begin
				a[t] = c.a[t];
				b[t] = c.b[t];
				w[t] = 0;
			end
			f = c.f;
			case (c.op)
				OP_ADD: for (int t = 0; t < 4; t++) w[t] = a[t] + b[t];
				OP_SUB: for (int t = 0; t < 4; t++) w[t] = a[t] - b[t];
				OP_NEG: for (int t = 0; t < 4; t++) w[t] = -a[t];
				OP_CONJ: begin
					w[0] = a[0];
					for (int t = 1; t < 4; t++) w[t] = -a[t];
				end
				OP_HAM: begin
					w[0] = fx_mul(a[0], b[0]) - fx_mul(a[1], b[1])
						- fx_mul(a[2], b[2]) - fx_mul(a[3], b[3]);
					w[1] = fx_mul(a[0], b[1]) + fx_mul(a[1], b[0])
						+ fx_mul(a[2], b[3]) - fx_mul(a[3], b[2]);
					w[2] = fx_mul(a[0], b[2]) - fx_mul(a[1], b[3])
						+ fx_mul(a[2], b[0]) + fx_mul(a[3], b[1]);
					w[3] = fx_mul(a[0], b[3]) + fx_mul(a[1], b[2])
						- fx_mul(a[2], b[1]) + fx_mul(a[3], b[0]);
				end
				OP_CMUL: for (int t = 0; t < 4; t++) w[t] = fx_mul(a[t], b[t]);
				OP_SCALE: for (int t = 0; t < 4; t++) w[t] = fx_mul(a[t], f);
				OP_DIV: for (int t = 0; t < 4; t++) w[t] = fx_div(a[t], f, p.err);
				OP_INV: begin
					nrm = 0;
					for (int t = 0; t < 4; t++) nrm += fx_mul(a[t], a[t]);
					w[0] = fx_div(a[0], nrm, p.err);
					for (int t = 1; t < 4; t++) w[t] = fx_div(-a[t], nrm, p.err);
				end
				default: ;
			endcase
			for (int t = 0; t < 4; t++) begin
				if (w[t] > SAT_HI) begin
					w[t] = SAT_HI;
					p.sat = 1'b1;
				end else if (w[t] < SAT_LO) begin
					w[t] = SAT_LO;
					p.sat = 1'b1;
				end
				p.r[t] = comp_t'(w[t]);
			end
			return p;
		endfunction

		function void note_command(quat_cmd_t c);
			quat_res_t p;
			p = predict_quat(c);
			op_count[c.op]++;
			if (p.sat) sat_seen++;
			if (p.err) err_seen++;
			expected_results.push_back(p);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(quat_res_t got);
			quat_res_t e;
			if (expected_results.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			e = expected_results.pop_front();
			checked++;
			for (int t = 0; t < 4; t++)
				if (got.r[t] !== e.r[t])
					report($sformatf("component %0d got %0d want %0d", t, got.r[t], e.r[t]));
			if (got.sat !== e.sat)
				report($sformatf("saturated got %b want %b", got.sat, e.sat));
			if (got.err !== e.err)
				report($sformatf("divide_error got %b want %b", got.err, e.err));
		endtask
	endclass

	logic clk;
	logic arst_n;
	quat_scoreboard sb;

	qalu_cmd_if cmd_ch ();
	qalu_res_if res_ch ();

	quaternion_alu_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("timeout");
		$display("FAILED: results differ");
		$finish;
	end

	// receiver stall pattern in one of four styles, chosen anew at random
	int unsigned cyc;
	int unsigned stall_mode;
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 64 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 9) < 7);
			2: res_ch.ready <= (cyc % 16 < 3);
			default: res_ch.ready <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		quat_cmd_t c;
		quat_res_t g;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				c.op = cmd_ch.command;
				c.a[0] = cmd_ch.a_re;
				c.a[1] = cmd_ch.a_i;
				c.a[2] = cmd_ch.a_j;
				c.a[3] = cmd_ch.a_k;
				c.b[0] = cmd_ch.b_re;
				c.b[1] = cmd_ch.b_i;
				c.b[2] = cmd_ch.b_j;
				c.b[3] = cmd_ch.b_k;
				c.f = cmd_ch.factor;
				sb.note_command(c);
			end
			if (res_ch.valid && res_ch.ready) begin
				g.r[0] = res_ch.r_re;
				g.r[1] = res_ch.r_i;
				g.r[2] = res_ch.r_j;
				g.r[3] = res_ch.r_k;
				g.sat = res_ch.saturated;
				g.err = res_ch.divide_error;
				sb.check_result(g);
			end
		end
	end

	function automatic comp_t rand_comp();
		case ($urandom_range(0, 6))
			0, 1: return comp_t'($urandom());
			2: return comp_t'($urandom_range(0, 1 << 19)) - comp_t'(1 << 18);
			3: return comp_t'($urandom_range(0, 1 << 25)) - comp_t'(1 << 24);
			4: begin
				case ($urandom_range(0, 4))
					0: return comp_t'(32'h7fffffff);
					1: return comp_t'(32'h80000000);
					2: return '0;
					3: return comp_t'(1 << FRAC);
					default: return comp_t'(-1);
				endcase
			end
			default: return comp_t'($urandom_range(0, 1 << 21)) - comp_t'(1 << 20);
		endcase
	endfunction

	function automatic quat_cmd_t make_cmd(logic [CMD_W-1:0] op, comp_t a0, comp_t a1,
		comp_t a2, comp_t a3, comp_t b0, comp_t b1, comp_t b2, comp_t b3, comp_t f);
		quat_cmd_t c;
		c.op = op;
		c.a = '{a0, a1, a2, a3};
		c.b = '{b0, b1, b2, b3};
		c.f = f;
		return c;
	endfunction

	function automatic quat_cmd_t random_cmd();
		quat_cmd_t c;
		if ($urandom_range(0, 19) == 0)
			c.op = CMD_W'($urandom_range(9, 15));
		else
			c.op = CMD_W'($urandom_range(0, 8));
		for (int t = 0; t < 4; t++) begin
			c.a[t] = rand_comp();
			c.b[t] = rand_comp();
		end
		c.f = ($urandom_range(0, 9) == 0) ? comp_t'(0) : rand_comp();
		return c;
	endfunction

	task automatic push_item(quat_cmd_t c);
		cmd_ch.valid   <= 1'b1;
		cmd_ch.command <= c.op;
		cmd_ch.a_re    <= c.a[0];
		cmd_ch.a_i     <= c.a[1];
		cmd_ch.a_j     <= c.a[2];
		cmd_ch.a_k     <= c.a[3];
		cmd_ch.b_re    <= c.b[0];
		cmd_ch.b_i     <= c.b[1];
		cmd_ch.b_j     <= c.b[2];
		cmd_ch.b_k     <= c.b[3];
		cmd_ch.factor  <= c.f;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
	endtask

	task automatic idle_sender(int n);
		cmd_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		idle_sender(1);
		while (sb.expected_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		quat_cmd_t dir [$];
		comp_t mx, mn, one;
		int sent, burst;
		sb = new();
		mx = comp_t'(32'h7fffffff);
		mn = comp_t'(32'h80000000);
		one = comp_t'(1 << FRAC);
		arst_n = 1'b0;
		cyc = 0;
		stall_mode = 0;
		res_ch.ready = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = '0;
		{cmd_ch.a_re, cmd_ch.a_i, cmd_ch.a_j, cmd_ch.a_k} = '0;
		{cmd_ch.b_re, cmd_ch.b_i, cmd_ch.b_j, cmd_ch.b_k} = '0;
		cmd_ch.factor = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir.push_back(make_cmd(OP_ADD, mx, mn, one, 0, mx, mn, -one, 0, 0));
		dir.push_back(make_cmd(OP_ADD, mx, mn, 1, -1, 1, -1, mx, mn, 0));
		dir.push_back(make_cmd(OP_SUB, mx, mn, 0, one, mn, mx, 0, one, 0));
		dir.push_back(make_cmd(OP_NEG, mn, mx, 0, -1, 0, 0, 0, 0, 0));
		dir.push_back(make_cmd(OP_CONJ, mn, mn, mx, 1, 0, 0, 0, 0, 0));
		dir.push_back(make_cmd(OP_HAM, one, 2 * one, -3 * one, 4 * one,
			-one, one, one, -2 * one, 0));
		dir.push_back(make_cmd(OP_HAM, mx, mn, mx, mn, mx, mx, mn, mn, 0));
		dir.push_back(make_cmd(OP_CMUL, mx, mn, -1, 3, mx, mn, 1, -1, 0));
		dir.push_back(make_cmd(OP_CMUL, one, -one, 5, -5, 2 * one, one, 1, 1, 0));
		dir.push_back(make_cmd(OP_SCALE, one, -one, mx, mn, 0, 0, 0, 0, 2 * one));
		dir.push_back(make_cmd(OP_SCALE, mx, mn, 7, -7, 0, 0, 0, 0, mn));
		dir.push_back(make_cmd(OP_DIV, mx, -one, 0, mn, 0, 0, 0, 0, 0));
		dir.push_back(make_cmd(OP_DIV, one, -3 * one, mx, mn, 0, 0, 0, 0, 3 * one));
		dir.push_back(make_cmd(OP_DIV, mx, mn, 1, -1, 0, 0, 0, 0, 1));
		dir.push_back(make_cmd(OP_DIV, -7, 7, mn, mx, 0, 0, 0, 0, -1));
		dir.push_back(make_cmd(OP_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_cmd(OP_INV, 1, -1, 100, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_cmd(OP_INV, one, one, -one, 2 * one, 0, 0, 0, 0, 0));
		dir.push_back(make_cmd(OP_INV, mx, mn, mx, mn, 0, 0, 0, 0, 0));
		dir.push_back(make_cmd(OP_INV, 0, 4 * one, 0, 0, 0, 0, 0, 0, 0));
		dir.push_back(make_cmd(CMD_W'(9), mx, mn, 1, 1, mx, mn, 1, 1, mx));
		dir.push_back(make_cmd(CMD_W'(15), mn, mx, -1, 1, 1, 1, 1, 1, 0));
		foreach (dir[i]) push_item(dir[i]);
		drain();

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 24);
			for (int i = 0; i < burst && sent < N_RANDOM; i++) begin
				push_item(random_cmd());
				sent++;
			end
			if (sent >= N_RANDOM / 2 && sent - burst < N_RANDOM / 2)
				drain();
			else if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 8));
		end
		drain();
		repeat (LAT + 10) @(posedge clk);

		$display("%0d results checked, %0d saturating and %0d divide-by-zero cases",
			sb.checked, sb.sat_seen, sb.err_seen);
		$display("items per opcode 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
			sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3],
			sb.op_count[4], sb.op_count[5], sb.op_count[6], sb.op_count[7],
			sb.op_count[8]);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (sb.expected_results.size() != 0)
				$display("%0d results never arrived", sb.expected_results.size());
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

`default_nettype wire
